// File: rtl/gbb_pkg.sv
package gbb_pkg;

    localparam int COORD_BITS = 12;
    localparam int MAX_PITCH  = 512;
    localparam int PITCH_BITS = 10;
    localparam int LINE_BITS  = 14;
    localparam int ADDR_BITS  = 26;
    localparam int COLOR_BITS = 32;
    localparam int CNT_BITS   = 4;
    localparam int Q_DEPTH    = 4;
    localparam int Q_PTR_BITS = $clog2(Q_DEPTH);

    // register indexes
    localparam logic [1:0] REG_LINE_BYTES   = 2'd0;
    localparam logic [1:0] REG_PIXEL_FORMAT = 2'd1;
    localparam logic [1:0] REG_FORE_COLOR   = 2'd2;
    localparam logic [1:0] REG_BACK_COLOR   = 2'd3;

    // framebuffer formats
    localparam logic [1:0] PF_8BPP  = 2'd0;
    localparam logic [1:0] PF_16BPP = 2'd1;
    localparam logic [1:0] PF_32BPP = 2'd2;

    // write sizes
    localparam logic [1:0] WS_BYTE = 2'd0;
    localparam logic [1:0] WS_HALF = 2'd1;
    localparam logic [1:0] WS_WORD = 2'd2;

    // glyph depths and actions
    localparam logic [1:0] GD_1BPP = 2'd0;
    localparam logic [1:0] GD_8BPP = 2'd1;
    localparam logic       ACT_START = 1'b0;

    localparam logic ST_PIXEL = 1'b0;
    localparam logic ST_ERROR = 1'b1;

    typedef struct packed {
        logic                  action;
        logic [COORD_BITS-1:0] x_left;
        logic [COORD_BITS-1:0] y_top;
        logic [COORD_BITS-1:0] x_end;
        logic [COORD_BITS-1:0] y_end;
        logic [PITCH_BITS-1:0] row_pitch;
        logic [1:0]            glyph_depth;
        logic [7:0]            data_byte;
    } t_in_item;

    typedef struct packed {
        logic [ADDR_BITS-1:0]  write_address;
        logic [COLOR_BITS-1:0] write_data;
        logic [1:0]            write_size;
        logic                  status;
        logic                  glyph_done;
        logic                  last;
    } t_out_item;

    // one run of pixels from one input beat
    typedef struct packed {
        logic                  err;
        logic [COORD_BITS-1:0] y;
        logic [COORD_BITS-1:0] x;
        logic [CNT_BITS-1:0]   cnt;
        logic [7:0]            bits;
        logic                  done_end;
    } t_job;

    typedef struct packed {
        logic [LINE_BITS-1:0]  line_bytes;
        logic [1:0]            pixel_format;
        logic [COLOR_BITS-1:0] fore_color;
        logic [COLOR_BITS-1:0] back_color;
    } t_cfg;

endpackage

// File: rtl/gbb_front.sv
module gbb_front (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    output logic             o_ready,
    input  gbb_pkg::t_in_item i_item,
    input  logic             i_q_full,
    output logic             o_push,
    output gbb_pkg::t_job    o_job
);
    import gbb_pkg::*;

    logic [COORD_BITS-1:0] r_cur_x, r_cur_y, r_left, r_right, r_bottom;
    logic [PITCH_BITS-1:0] r_row_bytes, r_pitch;
    logic                  r_depth8, r_active;
    logic [COORD_BITS-1:0] n_cur_x, n_cur_y, n_left, n_right, n_bottom;
    logic [PITCH_BITS-1:0] n_row_bytes, n_pitch;
    logic                  n_depth8, n_active;

    logic                  accept;
    logic [COORD_BITS:0]   x_plus1, y_plus1;
    logic                  last_row, have_px;
    logic [COORD_BITS-1:0] remain, new_x;
    logic [CNT_BITS-1:0]   cnt1;
    logic [PITCH_BITS-1:0] rbc_inc, pitch_sat;

    assign o_ready = !i_q_full;
    assign accept  = i_valid && o_ready;

    assign x_plus1  = {1'b0, r_cur_x} + 1'b1;
    assign y_plus1  = {1'b0, r_cur_y} + 1'b1;
    assign last_row = y_plus1 >= {1'b0, r_bottom};
    assign have_px  = r_cur_x < r_right;
    assign remain   = r_right - r_cur_x;
    assign cnt1     = !have_px ? '0 :
                      (remain >= COORD_BITS'(8)) ? CNT_BITS'(8) : remain[CNT_BITS-1:0];
    assign new_x    = r_cur_x + COORD_BITS'(cnt1);
    assign rbc_inc  = r_row_bytes + 1'b1;
    assign pitch_sat = (i_item.row_pitch > PITCH_BITS'(MAX_PITCH)) ?
                       PITCH_BITS'(MAX_PITCH) : i_item.row_pitch;

    always_comb begin
        n_cur_x     = r_cur_x;
        n_cur_y     = r_cur_y;
        n_left      = r_left;
        n_right     = r_right;
        n_bottom    = r_bottom;
        n_row_bytes = r_row_bytes;
        n_pitch     = r_pitch;
        n_depth8    = r_depth8;
        n_active    = r_active;
        o_push      = 1'b0;
        o_job       = '0;
        o_job.y     = r_cur_y;
        o_job.x     = r_cur_x;
        if (accept) begin
            if (i_item.action == ACT_START) begin
                n_active = 1'b0;
                if (i_item.glyph_depth != GD_1BPP && i_item.glyph_depth != GD_8BPP) begin
                    o_push    = 1'b1;
                    o_job     = '0;
                    o_job.err = 1'b1;
                    o_job.cnt = CNT_BITS'(1);
                end else begin
                    n_left      = i_item.x_left;
                    n_right     = i_item.x_end;
                    n_bottom    = i_item.y_end;
                    n_cur_x     = i_item.x_left;
                    n_cur_y     = i_item.y_top;
                    n_row_bytes = '0;
                    n_pitch     = pitch_sat;
                    n_depth8    = (i_item.glyph_depth == GD_8BPP);
                    n_active    = (i_item.x_end > i_item.x_left) &&
                                  (i_item.y_end > i_item.y_top);
                end
            end else if (r_active) begin
                if (r_depth8) begin
                    o_push         = 1'b1;
                    o_job.cnt      = CNT_BITS'(1);
                    o_job.bits     = {(i_item.data_byte != 8'd0), 7'd0};
                    o_job.done_end = last_row && (x_plus1 >= {1'b0, r_right});
                    n_cur_x        = x_plus1[COORD_BITS-1:0];
                    if (x_plus1 >= {1'b0, r_right}) begin
                        n_cur_x     = r_left;
                        n_row_bytes = '0;
                        n_cur_y     = y_plus1[COORD_BITS-1:0];
                        n_active    = !last_row;
                    end
                end else begin
                    // padding bytes push no run
                    o_push         = have_px;
                    o_job.cnt      = cnt1;
                    o_job.bits     = i_item.data_byte;
                    o_job.done_end = last_row && have_px && (new_x >= r_right);
                    n_cur_x        = new_x;
                    n_row_bytes    = rbc_inc;
                    if (rbc_inc >= r_pitch && new_x >= r_right) begin
                        n_cur_x     = r_left;
                        n_row_bytes = '0;
                        n_cur_y     = y_plus1[COORD_BITS-1:0];
                        n_active    = !last_row;
                    end
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cur_x     <= '0;
            r_cur_y     <= '0;
            r_left      <= '0;
            r_right     <= '0;
            r_bottom    <= '0;
            r_row_bytes <= '0;
            r_pitch     <= '0;
            r_depth8    <= 1'b0;
            r_active    <= 1'b0;
        end else begin
            r_cur_x     <= n_cur_x;
            r_cur_y     <= n_cur_y;
            r_left      <= n_left;
            r_right     <= n_right;
            r_bottom    <= n_bottom;
            r_row_bytes <= n_row_bytes;
            r_pitch     <= n_pitch;
            r_depth8    <= n_depth8;
            r_active    <= n_active;
        end
    end

endmodule

// File: rtl/gbb_fifo.sv
module gbb_fifo (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  gbb_pkg::t_job i_job,
    input  logic          i_pop,
    output gbb_pkg::t_job o_job,
    output logic          o_empty,
    output logic          o_full
);
    import gbb_pkg::*;

    t_job                r_mem [Q_DEPTH];
    logic [Q_PTR_BITS-1:0] r_wr_ptr, r_rd_ptr;
    logic [Q_PTR_BITS:0]   r_count;
    logic                  do_push, do_pop;

    assign o_empty = (r_count == '0);
    assign o_full  = (r_count == (Q_PTR_BITS+1)'(Q_DEPTH));
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;
    assign o_job   = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_job;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (do_pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            if (do_push && !do_pop) begin
                r_count <= r_count + 1'b1;
            end else if (do_pop && !do_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

endmodule

// File: rtl/gbb_back.sv
module gbb_back (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  gbb_pkg::t_cfg     i_cfg,
    input  gbb_pkg::t_job     i_job,
    input  logic              i_empty,
    output logic              o_pop,
    output logic              o_valid,
    input  logic              i_ready,
    output gbb_pkg::t_out_item o_item
);
    import gbb_pkg::*;

    logic [2:0]            r_idx;
    logic                  r_valid;
    t_out_item             r_item;
    t_out_item             pix;
    logic                  adv, is_last, fg;
    logic [COORD_BITS-1:0] px;
    logic [COLOR_BITS-1:0] col;
    logic [LINE_BITS+1:0]  xoff;
    logic [ADDR_BITS-1:0]  row_base;

    assign adv     = !i_empty && (!r_valid || i_ready);
    assign is_last = ({1'b0, r_idx} + 1'b1) == i_job.cnt;
    assign px      = i_job.x + COORD_BITS'(r_idx);
    assign fg      = i_job.bits[3'd7 - r_idx];
    assign col     = fg ? i_cfg.fore_color : i_cfg.back_color;
    assign row_base = ADDR_BITS'(i_job.y * i_cfg.line_bytes);

    always_comb begin
        pix = '0;
        unique case (i_cfg.pixel_format)
            PF_8BPP: begin
                pix.write_size = WS_BYTE;
                pix.write_data = {24'd0, col[7:0]};
                xoff           = (LINE_BITS+2)'(px);
            end
            PF_16BPP: begin
                pix.write_size = WS_HALF;
                pix.write_data = {16'd0, col[23:19], col[15:10], col[7:3]};
                xoff           = (LINE_BITS+2)'({px, 1'b0});
            end
            default: begin
                pix.write_size = WS_WORD;
                pix.write_data = col;
                xoff           = (LINE_BITS+2)'({px, 2'b00});
            end
        endcase
        pix.write_address = row_base + ADDR_BITS'(xoff);
        pix.status        = ST_PIXEL;
        pix.glyph_done    = is_last && i_job.done_end;
        pix.last          = is_last;
        if (i_job.err) begin
            pix        = '0;
            pix.status = ST_ERROR;
            pix.last   = 1'b1;
        end
    end

    assign o_pop   = adv && is_last;
    assign o_valid = r_valid;
    assign o_item  = r_item;

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_item <= pix;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_idx   <= '0;
        end else begin
            if (adv) begin
                r_valid <= 1'b1;
                r_idx   <= is_last ? '0 : r_idx + 1'b1;
            end else if (i_ready) begin
                r_valid <= 1'b0;
            end
        end
    end

endmodule

// File: rtl/glyph_bitmap_blitter.sv
// channel  | direction | handshake                 | payload
// input    | in        | i_in_valid / o_in_ready   | i_in_data (t_in_item)
// output   | out       | o_out_valid / i_out_ready | o_out_data (t_out_item)
// config   | in        | i_cfg_valid / o_cfg_ready | i_cfg_index, i_cfg_data
//
// a valid start beat or a padding beat stays in the front end and queues no run
// a 1 bpp byte gives as many framebuffer writes as pixels it paints (up to 8),
// one per cycle from the back end while the output is not stalled; an 8 bpp byte gives one
// a four-entry run queue lets the front keep taking beats while the back drains
// results are registered and reach the port in the cycle after the back end picks them up
// reset is synchronous active low and clears all control state
module glyph_bitmap_blitter (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  gbb_pkg::t_in_item  i_in_data,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output gbb_pkg::t_out_item o_out_data,
    input  logic               i_cfg_valid,
    output logic               o_cfg_ready,
    input  logic [1:0]         i_cfg_index,
    input  logic [31:0]        i_cfg_data
);
    import gbb_pkg::*;

    t_cfg r_cfg;
    t_job push_job, head_job;
    logic push, pop, q_empty, q_full;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.line_bytes   <= '0;
            r_cfg.pixel_format <= PF_32BPP;
            r_cfg.fore_color   <= 32'h00FF_FFFF;
            r_cfg.back_color   <= '0;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                REG_LINE_BYTES:   r_cfg.line_bytes   <= i_cfg_data[LINE_BITS-1:0];
                REG_PIXEL_FORMAT: r_cfg.pixel_format <= i_cfg_data[1:0];
                REG_FORE_COLOR:   r_cfg.fore_color   <= i_cfg_data;
                REG_BACK_COLOR:   r_cfg.back_color   <= i_cfg_data;
            endcase
        end
    end

    gbb_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (i_in_valid),
        .o_ready  (o_in_ready),
        .i_item   (i_in_data),
        .i_q_full (q_full),
        .o_push   (push),
        .o_job    (push_job)
    );

    gbb_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_job   (push_job),
        .i_pop   (pop),
        .o_job   (head_job),
        .o_empty (q_empty),
        .o_full  (q_full)
    );

    gbb_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (r_cfg),
        .i_job   (head_job),
        .i_empty (q_empty),
        .o_pop   (pop),
        .o_valid (o_out_valid),
        .i_ready (i_out_ready),
        .o_item  (o_out_data)
    );

    // the glyph's final pixel always closes the run of its beat
    a_done_is_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_data.glyph_done |-> o_out_data.last)
        else $error("glyph_done without last");

    a_error_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_data.status == ST_ERROR |->
            o_out_data.last && !o_out_data.glyph_done &&
            o_out_data.write_address == '0)
        else $error("malformed error result");

    a_no_push_when_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        q_full |-> !push)
        else $error("run queue overflow");

    a_reset_clears_out: assert property (@(posedge i_clk)
        $past(!i_rst_n) && i_rst_n |-> !o_out_valid)
        else $error("output valid after reset");

endmodule

// File: verif/glyph_bitmap_blitter_checker.sv
module glyph_bitmap_blitter_checker (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    input  logic               i_in_ready,
    input  gbb_pkg::t_in_item  i_in_data,
    input  logic               i_out_valid,
    input  logic               i_out_ready,
    input  gbb_pkg::t_out_item i_out_data,
    input  logic               i_cfg_valid,
    input  logic               i_cfg_ready,
    input  logic [1:0]         i_cfg_index,
    input  logic [31:0]        i_cfg_data,
    output int                 o_errors,
    output int                 o_awaited,
    output int                 o_pixel_writes,
    output int                 o_depth_errors,
    output int                 o_glyphs_done
);
    import gbb_pkg::*;

    t_cfg                  cfg;
    logic [COORD_BITS-1:0] col;
    logic [COORD_BITS-1:0] row;
    logic [PITCH_BITS-1:0] row_bytes;
    logic [COORD_BITS-1:0] glyph_left;
    logic [COORD_BITS-1:0] glyph_right;
    logic [COORD_BITS-1:0] glyph_bottom;
    logic [PITCH_BITS-1:0] glyph_pitch;
    logic                  gray_mode;
    logic                  glyph_open;

    t_out_item awaited_writes[$];

    initial begin
        o_errors       = 0;
        o_awaited      = 0;
        o_pixel_writes = 0;
        o_depth_errors = 0;
        o_glyphs_done  = 0;
    end

    task automatic flag(string msg);
        $display("mismatch at %0t: %s", $time, msg);
        o_errors = o_errors + 1;
    endtask

    function automatic t_out_item shade_pixel(logic [COORD_BITS-1:0] x,
                                              logic [COORD_BITS-1:0] y,
                                              logic fg, logic done, logic tail);
        t_out_item             px;
        logic [COLOR_BITS-1:0] color;
        logic [31:0]           offset;
        color = fg ? cfg.fore_color : cfg.back_color;
        px = '0;
        case (cfg.pixel_format)
            PF_8BPP: begin
                px.write_size = WS_BYTE;
                px.write_data = {24'd0, color[7:0]};
                offset = 32'(x);
            end
            PF_16BPP: begin
                px.write_size = WS_HALF;
                px.write_data = {16'd0, color[23:19], color[15:10], color[7:3]};
                offset = 32'(x) * 2;
            end
            default: begin
                px.write_size = WS_WORD;
                px.write_data = color;
                offset = 32'(x) * 4;
            end
        endcase
        px.write_address = ADDR_BITS'(32'(y) * 32'(cfg.line_bytes) + offset);
        px.status     = ST_PIXEL;
        px.glyph_done = done;
        px.last       = tail;
        return px;
    endfunction

    task automatic close_row();
        col       = glyph_left;
        row_bytes = '0;
        row       = row + 1'b1;
        if (row >= glyph_bottom) begin
            glyph_open = 1'b0;
        end
    endtask

    task automatic expand_beat(t_in_item beat);
        t_out_item err;
        logic      done;
        if (beat.action == ACT_START) begin
            glyph_open = 1'b0;
            if (beat.glyph_depth != GD_1BPP && beat.glyph_depth != GD_8BPP) begin
                err = '0;
                err.write_size = WS_BYTE;
                err.status     = ST_ERROR;
                err.last       = 1'b1;
                awaited_writes.push_back(err);
                return;
            end
            glyph_pitch  = (beat.row_pitch > MAX_PITCH) ? PITCH_BITS'(MAX_PITCH)
                                                        : beat.row_pitch;
            glyph_left   = beat.x_left;
            glyph_right  = beat.x_end;
            glyph_bottom = beat.y_end;
            col          = beat.x_left;
            row          = beat.y_top;
            row_bytes    = '0;
            gray_mode    = (beat.glyph_depth == GD_8BPP);
            glyph_open   = (beat.x_end > beat.x_left) && (beat.y_end > beat.y_top);
        end else if (glyph_open) begin
            if (gray_mode) begin
                done = (col + 1 >= glyph_right) && (row + 1 >= glyph_bottom);
                awaited_writes.push_back(shade_pixel(col, row, beat.data_byte != 8'd0,
                                                     done, 1'b1));
                col = col + 1'b1;
                if (col >= glyph_right) begin
                    close_row();
                end
            end else begin
                // msb first, bits past the right edge paint nothing
                for (int bit_pos = 7; bit_pos >= 0; bit_pos--) begin
                    if (col < glyph_right) begin
                        done = (col + 1 >= glyph_right) && (row + 1 >= glyph_bottom);
                        awaited_writes.push_back(shade_pixel(col, row,
                            beat.data_byte[bit_pos], done,
                            (col + 1 >= glyph_right) || (bit_pos == 0)));
                        col = col + 1'b1;
                    end
                end
                row_bytes = row_bytes + 1'b1;
                if (row_bytes >= glyph_pitch && col >= glyph_right) begin
                    close_row();
                end
            end
        end
    endtask

    always @(posedge i_clk) begin
        t_out_item want;
        if (!i_rst_n) begin
            cfg.line_bytes   = '0;
            cfg.pixel_format = PF_32BPP;
            cfg.fore_color   = 32'h00FF_FFFF;
            cfg.back_color   = '0;
            col          = '0;
            row          = '0;
            row_bytes    = '0;
            glyph_left   = '0;
            glyph_right  = '0;
            glyph_bottom = '0;
            glyph_pitch  = '0;
            gray_mode    = 1'b0;
            glyph_open   = 1'b0;
            awaited_writes.delete();
        end else begin
            if (i_cfg_valid && i_cfg_ready) begin
                case (i_cfg_index)
                    REG_LINE_BYTES:   cfg.line_bytes   = i_cfg_data[LINE_BITS-1:0];
                    REG_PIXEL_FORMAT: cfg.pixel_format = i_cfg_data[1:0];
                    REG_FORE_COLOR:   cfg.fore_color   = i_cfg_data;
                    REG_BACK_COLOR:   cfg.back_color   = i_cfg_data;
                    default: ;
                endcase
            end
            if (i_out_valid && i_out_ready) begin
                if (awaited_writes.size() == 0) begin
                    flag($sformatf("unexpected write beat addr %h data %h",
                                   i_out_data.write_address, i_out_data.write_data));
                end else begin
                    want = awaited_writes.pop_front();
                    if (i_out_data.write_address !== want.write_address)
                        flag($sformatf("write_address got %h want %h",
                                       i_out_data.write_address, want.write_address));
                    if (i_out_data.write_data !== want.write_data)
                        flag($sformatf("write_data got %h want %h",
                                       i_out_data.write_data, want.write_data));
                    if (i_out_data.write_size !== want.write_size)
                        flag($sformatf("write_size got %0d want %0d",
                                       i_out_data.write_size, want.write_size));
                    if (i_out_data.status !== want.status)
                        flag($sformatf("status got %b want %b",
                                       i_out_data.status, want.status));
                    if (i_out_data.glyph_done !== want.glyph_done)
                        flag($sformatf("glyph_done got %b want %b at addr %h",
                                       i_out_data.glyph_done, want.glyph_done,
                                       want.write_address));
                    if (i_out_data.last !== want.last)
                        flag($sformatf("last got %b want %b at addr %h",
                                       i_out_data.last, want.last, want.write_address));
                    if (want.status == ST_ERROR) begin
                        o_depth_errors = o_depth_errors + 1;
                    end else begin
                        o_pixel_writes = o_pixel_writes + 1;
                    end
                    if (want.glyph_done) begin
                        o_glyphs_done = o_glyphs_done + 1;
                    end
                end
            end
            if (i_in_valid && i_in_ready) begin
                expand_beat(i_in_data);
            end
        end
        o_awaited <= awaited_writes.size();
    end

endmodule

// File: verif/tb_glyph_bitmap_blitter.sv
module tb_glyph_bitmap_blitter;
    import gbb_pkg::*;

    localparam logic       ACT_BYTE     = ~ACT_START;
    localparam logic [1:0] GD_NONE      = 2'd2;
    localparam logic [1:0] GD_RESERVED  = 2'd3;
    localparam int         DRAIN_CYCLES = 40;
    localparam int         SEGMENTS     = 6;
    localparam int         SEG_BEATS    = 64;
    localparam int         HOLD_OFF     = 300;
    localparam int         BROKEN_CAP   = 40;

    logic       i_clk = 1'b0;
    logic       i_rst_n = 1'b0;
    logic       i_in_valid = 1'b0;
    logic       o_in_ready;
    t_in_item   i_in_data = '0;
    logic       o_out_valid;
    logic       i_out_ready = 1'b0;
    t_out_item  o_out_data;
    logic       i_cfg_valid = 1'b0;
    logic       o_cfg_ready;
    logic [1:0] i_cfg_index = REG_LINE_BYTES;
    logic [31:0] i_cfg_data = '0;

    int mism_count;
    int awaited;
    int pixel_writes;
    int depth_errors;
    int glyphs_done;

    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    int hold_left = 0;
    int beats_sent = 0;
    int cfg_writes = 0;

    glyph_bitmap_blitter u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    glyph_bitmap_blitter_checker u_checker (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .i_in_ready     (o_in_ready),
        .i_in_data      (i_in_data),
        .i_out_valid    (o_out_valid),
        .i_out_ready    (i_out_ready),
        .i_out_data     (o_out_data),
        .i_cfg_valid    (i_cfg_valid),
        .i_cfg_ready    (o_cfg_ready),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data),
        .o_errors       (mism_count),
        .o_awaited      (awaited),
        .o_pixel_writes (pixel_writes),
        .o_depth_errors (depth_errors),
        .o_glyphs_done  (glyphs_done)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    initial begin
        #4_000_000;
        $display("tb_glyph_bitmap_blitter: done, errors");
        $finish;
    end

    // receiver: random stalls, plus a long hold-off on request
    initial begin
        forever begin
            @(posedge i_clk);
            if (hold_left > 0) begin
                i_out_ready <= 1'b0;
                hold_left = hold_left - 1;
            end else begin
                i_out_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
            end
        end
    end

    function automatic t_in_item noise_beat();
        logic [95:0] r;
        r = {$urandom, $urandom, $urandom};
        return r[$bits(t_in_item)-1:0];
    endfunction

    function automatic t_in_item start_beat(int x, int y, int w, int h, int pitch,
                                            logic [1:0] depth);
        t_in_item beat;
        beat = noise_beat();
        beat.action      = ACT_START;
        beat.x_left      = COORD_BITS'(x);
        beat.x_end       = COORD_BITS'(x + w);
        beat.y_top       = COORD_BITS'(y);
        beat.y_end       = COORD_BITS'(y + h);
        beat.row_pitch   = PITCH_BITS'(pitch);
        beat.glyph_depth = depth;
        return beat;
    endfunction

    function automatic t_in_item byte_beat(logic [7:0] b);
        t_in_item beat;
        beat = noise_beat();
        beat.action    = ACT_BYTE;
        beat.data_byte = b;
        return beat;
    endfunction

    task automatic send_beat(t_in_item beat);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_data  <= beat;
        do @(posedge i_clk); while (!o_in_ready);
        beats_sent = beats_sent + 1;
    endtask

    task automatic cfg_beat(logic [1:0] idx, logic [31:0] val);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        do @(posedge i_clk); while (!o_cfg_ready);
        cfg_writes = cfg_writes + 1;
    endtask

    task automatic load_setting(logic [13:0] lb, logic [1:0] pf,
                                logic [31:0] fg, logic [31:0] bg);
        cfg_beat(REG_LINE_BYTES, {18'($urandom), lb});
        cfg_beat(REG_PIXEL_FORMAT, {30'($urandom), pf});
        cfg_beat(REG_FORE_COLOR, fg);
        cfg_beat(REG_BACK_COLOR, bg);
        i_cfg_valid <= 1'b0;
    endtask

    // stop offering, wait for every awaited write, then let trailing padding settle
    task automatic wait_quiet();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (awaited != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic send_glyph(logic [1:0] depth, int w, int h, int pitch, bit broken);
        int sat;
        int row_len;
        int total;
        int r;
        send_beat(start_beat($urandom_range(0, 4095 - w), $urandom_range(0, 4095 - h),
                             w, h, pitch, depth));
        sat = (pitch > MAX_PITCH) ? MAX_PITCH : pitch;
        if (depth == GD_8BPP) begin
            row_len = w;
        end else begin
            row_len = (sat > (w + 7) / 8) ? sat : (w + 7) / 8;
        end
        total = row_len * h;
        if (broken) begin
            total = $urandom_range(0, ((total > BROKEN_CAP) ? BROKEN_CAP : total) - 1);
        end
        for (int i = 0; i < total; i++) begin
            r = $urandom_range(0, 99);
            send_beat(byte_beat(r < 15 ? 8'h00 : r < 30 ? 8'hFF : 8'($urandom)));
        end
    endtask

    initial begin
        t_in_item    beat;
        int          target;
        int          pick;
        int          w;
        int          h;
        int          p;
        logic [13:0] lb;
        logic [31:0] fg;
        logic [31:0] bg;

        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        send_idle_pct = 12;
        recv_idle_pct = 49;
        load_setting(14'h3FFF, PF_16BPP, 32'hFFFF_FFFF, 32'h0000_0000);

        // byte with nothing open is dropped
        send_beat(byte_beat(8'hFF));
        send_beat(start_beat(0, 0, 1, 1, 0, GD_RESERVED));
        send_beat(start_beat(5, 5, 1, 1, 0, GD_NONE));
        // zero-width glyph, following byte dropped
        send_beat(start_beat(4095, 10, 0, 2, 0, GD_1BPP));
        send_beat(byte_beat(8'h5A));
        // glyph against the right and bottom edges of the coordinate space
        send_beat(start_beat(4088, 4094, 7, 1, 0, GD_1BPP));
        send_beat(byte_beat(8'hA5));
        // saturated pitch, abandoned by a new start mid-row
        send_beat(start_beat(100, 200, 9, 2, 1023, GD_1BPP));
        send_beat(byte_beat(8'h81));
        send_beat(byte_beat(8'h7F));
        send_beat(byte_beat(8'h00));
        send_beat(start_beat(0, 0, 2, 2, 5, GD_8BPP));
        send_beat(byte_beat(8'h00));
        send_beat(byte_beat(8'hFF));
        send_beat(byte_beat(8'h01));
        send_beat(byte_beat(8'h80));
        // one padding byte per row
        send_beat(start_beat(3000, 1, 3, 2, 2, GD_1BPP));
        send_beat(byte_beat(8'hE0));
        send_beat(byte_beat(8'h33));
        send_beat(byte_beat(8'h40));
        send_beat(byte_beat(8'h12));
        // pitch shorter than the row needs
        send_beat(start_beat(7, 3, 12, 1, 1, GD_1BPP));
        send_beat(byte_beat(8'hC3));
        send_beat(byte_beat(8'h3C));
        wait_quiet();

        for (int seg = 0; seg < SEGMENTS; seg++) begin
            send_idle_pct = (seg < 2) ? 12 : (seg < 4) ? 49 : 0;
            recv_idle_pct = (seg < 2) ? 49 : (seg < 4) ? 12 : 0;
            lb = (seg == 0) ? 14'h0000 : (seg == 1) ? 14'h3FFF : 14'($urandom);
            fg = (seg == 0) ? 32'hFFFF_FFFF : (seg == 1) ? 32'h0000_0000 : $urandom;
            bg = (seg == 0) ? 32'h0000_0000 : (seg == 1) ? 32'hFFFF_FFFF : $urandom;
            load_setting(lb, 2'(seg % 4), fg, bg);
            if (seg == 0) begin
                // long receiver stall while the sender keeps pushing
                hold_left = HOLD_OFF;
            end
            target = beats_sent + SEG_BEATS;
            while (beats_sent < target) begin
                pick = $urandom_range(0, 99);
                if (pick < 40) begin
                    w = $urandom_range(1, ($urandom_range(0, 3) == 0) ? 24 : 10);
                    h = $urandom_range(1, 3);
                    p = $urandom_range(0, 19);
                    if (p < 13) begin
                        send_glyph(GD_1BPP, w, h, $urandom_range(0, 3),
                                   $urandom_range(0, 4) == 0);
                    end else if (p < 18) begin
                        send_glyph(GD_1BPP, w, h, $urandom_range(4, 12),
                                   $urandom_range(0, 4) == 0);
                    end else begin
                        // huge pitch rows are never finished
                        send_glyph(GD_1BPP, w, h, $urandom_range(512, 1023), 1'b1);
                    end
                end else if (pick < 72) begin
                    send_glyph(GD_8BPP, $urandom_range(1, 8), $urandom_range(1, 3),
                               $urandom_range(0, 1023), $urandom_range(0, 4) == 0);
                end else if (pick < 78) begin
                    beat = noise_beat();
                    beat.action      = ACT_START;
                    beat.glyph_depth = $urandom_range(0, 1) ? GD_NONE : GD_RESERVED;
                    send_beat(beat);
                end else if (pick < 84) begin
                    beat = noise_beat();
                    beat.action      = ACT_START;
                    beat.glyph_depth = $urandom_range(0, 1) ? GD_8BPP : GD_1BPP;
                    if ($urandom_range(0, 1)) begin
                        beat.x_end = COORD_BITS'($urandom_range(0, beat.x_left));
                    end else begin
                        beat.y_end = COORD_BITS'($urandom_range(0, beat.y_top));
                    end
                    send_beat(beat);
                    repeat ($urandom_range(1, 2)) send_beat(byte_beat(8'($urandom)));
                end else begin
                    send_beat(noise_beat());
                end
            end
            wait_quiet();
        end

        $display("covered %0d input beats and %0d register writes over %0d settings",
                 beats_sent, cfg_writes, SEGMENTS + 1);
        $display("checked %0d pixel writes, %0d depth errors, %0d finished glyphs",
                 pixel_writes, depth_errors, glyphs_done);
        if (mism_count == 0 && awaited == 0) begin
            $display("tb_glyph_bitmap_blitter: done, clean");
        end else begin
            $display("tb_glyph_bitmap_blitter: done, errors");
        end
        $finish;
    end

endmodule

// File: files.f
rtl/gbb_pkg.sv
rtl/gbb_front.sv
rtl/gbb_fifo.sv
rtl/gbb_back.sv
rtl/glyph_bitmap_blitter.sv
verif/glyph_bitmap_blitter_checker.sv
verif/tb_glyph_bitmap_blitter.sv
